### rtl/core/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg: shared definitions of the quadratic root solver
// Holds the root classification codes and the fixed-point constants.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int COEF_WIDTH_DEF = 16;   // default coefficient width
    localparam int FRAC_SHIFT     = 16;   // -b is scaled to Q9.24
    localparam int SQRT_SHIFT     = 32;   // D is scaled by 2^32 before the root
    localparam int ROOT_WIDTH     = 32;   // width of a Q16.16 root

    typedef enum logic [1:0] {
        KIND_NOT_QUAD = 2'd0,
        KIND_NO_ROOTS = 2'd1,
        KIND_DOUBLE   = 2'd2,
        KIND_TWO      = 2'd3
    } t_kind;

endpackage

### rtl/core/qrs_if.sv
// ----------------------------------------------------------------------------
// qrs_if: stream channels of the quadratic root solver
// One interface for coefficient transfers, one for result transfers.
// ----------------------------------------------------------------------------
interface qrs_coef_if #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COEF_WIDTH-1:0] coef_a;
    logic signed [COEF_WIDTH-1:0] coef_b;
    logic signed [COEF_WIDTH-1:0] coef_c;

    modport source (output valid, coef_a, coef_b, coef_c, input ready);
    modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_root_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            kind;
    logic signed [qrs_pkg::ROOT_WIDTH-1:0] root_plus;
    logic signed [qrs_pkg::ROOT_WIDTH-1:0] root_minus;
    logic                                  saturated;

    modport source (output valid, kind, root_plus, root_minus, saturated, input ready);
    modport sink   (input valid, kind, root_plus, root_minus, saturated, output ready);
endinterface

### rtl/core/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// qrs_sqrt: pipelined integer square root
// Digit-by-digit restoring root, one result bit per register stage.
// ----------------------------------------------------------------------------
module qrs_sqrt #(
    parameter int RW  = 33,
    parameter int SBW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [2*RW-1:0] i_rad,
    input  logic [SBW-1:0]  i_sb,
    output logic            o_valid,
    output logic [RW-1:0]   o_root,
    output logic [SBW-1:0]  o_sb
);

    logic [2*RW-1:0] s_rad  [0:RW];
    logic [RW+1:0]   s_rem  [0:RW];
    logic [RW-1:0]   s_root [0:RW];
    logic [SBW-1:0]  s_sb   [0:RW];
    logic            s_vld  [0:RW];

    assign s_rad[0]  = i_rad;
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_sb[0]   = i_sb;
    assign s_vld[0]  = i_valid;

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [RW-1:0]   r_root;
        logic [RW+1:0]   r_rem;
        logic [2*RW-1:0] r_rad;
        logic [SBW-1:0]  r_sb;
        logic            r_vld;
        logic [RW+3:0]   n_trem;
        logic [RW+3:0]   n_trial;
        logic            n_take;

        always_comb begin
            n_trem  = {s_rem[k], s_rad[k][2*RW-1 -: 2]};
            n_trial = {2'b00, s_root[k], 2'b01};
            n_take  = (n_trem >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= s_vld[k];
            end
            if (i_en) begin
                r_rad  <= {s_rad[k][2*RW-3:0], 2'b00};
                r_sb   <= s_sb[k];
                r_root <= {s_root[k][RW-2:0], n_take};
                r_rem  <= n_take ? (RW+2)'(n_trem - n_trial) : (RW+2)'(n_trem);
            end
        end

        assign s_rad[k+1]  = r_rad;
        assign s_rem[k+1]  = r_rem;
        assign s_root[k+1] = r_root;
        assign s_sb[k+1]   = r_sb;
        assign s_vld[k+1]  = r_vld;
    end

    assign o_valid = s_vld[RW];
    assign o_root  = s_root[RW];
    assign o_sb    = s_sb[RW];

endmodule

### rtl/core/qrs_div.sv
// ----------------------------------------------------------------------------
// qrs_div: pipelined unsigned divider
// Restoring division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module qrs_div #(
    parameter int QW  = 34,
    parameter int DW  = 17,
    parameter int SBW = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [QW-1:0]  i_num,
    input  logic [DW-1:0]  i_den,
    input  logic [SBW-1:0] i_sb,
    output logic           o_valid,
    output logic [QW-1:0]  o_quot,
    output logic [SBW-1:0] o_sb
);

    logic [QW-1:0]  s_num [0:QW];
    logic [DW-1:0]  s_den [0:QW];
    logic [DW-1:0]  s_rem [0:QW];
    logic [SBW-1:0] s_sb  [0:QW];
    logic           s_vld [0:QW];

    assign s_num[0] = i_num;
    assign s_den[0] = i_den;
    assign s_rem[0] = '0;
    assign s_sb[0]  = i_sb;
    assign s_vld[0] = i_valid;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [QW-1:0]  r_num;
        logic [DW-1:0]  r_den;
        logic [DW-1:0]  r_rem;
        logic [SBW-1:0] r_sb;
        logic           r_vld;
        logic [DW:0]    n_trem;
        logic           n_take;

        always_comb begin
            n_trem = {s_rem[k], s_num[k][QW-1]};
            n_take = (n_trem >= {1'b0, s_den[k]});
        end

        // The numerator register shifts its consumed bit out and the
        // quotient bit in, so it ends holding the quotient.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= s_vld[k];
            end
            if (i_en) begin
                r_num <= {s_num[k][QW-2:0], n_take};
                r_den <= s_den[k];
                r_sb  <= s_sb[k];
                r_rem <= n_take ? DW'(n_trem - {1'b0, s_den[k]}) : DW'(n_trem);
            end
        end

        assign s_num[k+1] = r_num;
        assign s_den[k+1] = r_den;
        assign s_rem[k+1] = r_rem;
        assign s_sb[k+1]  = r_sb;
        assign s_vld[k+1] = r_vld;
    end

    assign o_valid = s_vld[QW];
    assign o_quot  = s_num[QW];
    assign o_sb    = s_sb[QW];

endmodule

### rtl/core/quadratic_root_solver_unit.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit: fixed-point quadratic equation solver
// Solves a*x^2 + b*x + c = 0 for Q8.8 coefficients, Q16.16 roots.
// ----------------------------------------------------------------------------
// Usage:
//   i_coef carries one equation per transfer: coef_a, coef_b and coef_c,
//   signed fixed point with eight fraction bits. o_root carries one result
//   per equation, in order: kind (not quadratic, no real roots, double
//   root, two roots), root_plus and root_minus in signed Q16.16 saturated
//   to 32 bits, and a flag telling whether either root was clamped.
//   From input transfer to output valid an equation passes three stages
//   for capture, products and discriminant, COEF_WIDTH+17 square root
//   stages, one numerator stage, COEF_WIDTH+18 divider stages and the
//   output register.
//   Throughput is one equation per cycle; a new transfer is taken every
//   cycle while the result side takes results.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and i_coef.ready drops in the same cycle; nothing is lost or
//   repeated. Reset clears every valid bit, so the pipeline comes up empty.
// ----------------------------------------------------------------------------
module quadratic_root_solver_unit #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    qrs_coef_if.sink   i_coef,
    qrs_root_if.source o_root
);

    localparam int W    = COEF_WIDTH;
    localparam int PW   = 2 * W;            // b*b and a*c
    localparam int DW   = 2 * W + 3;        // signed discriminant
    localparam int RW   = W + 17;           // bits of the square root
    localparam int NBW  = W + 17;           // -b scaled to Q9.24
    localparam int DENW = W + 1;            // 2a, signed or as magnitude
    localparam int NW   = W + 19;           // signed numerator
    localparam int QW   = W + 18;           // numerator and quotient magnitude
    localparam int CW   = (QW + 1 > 33) ? QW + 1 : 33;
    localparam int SB1  = 2 + NBW + DENW;

    localparam logic signed [CW-1:0] MAX_ROOT = CW'(64'sd2147483647);
    localparam logic signed [CW-1:0] MIN_ROOT = CW'(-64'sd2147483648);

    // The whole pipeline advances together unless a result is stuck.
    logic w_en;
    logic r_out_valid;
    assign w_en         = !r_out_valid || o_root.ready;
    assign i_coef.ready = w_en;

    // Stage 1: capture the coefficients.
    logic                r1_vld;
    logic signed [W-1:0] r1_a, r1_b, r1_c;

    // Stage 2: the two products.
    logic                 r2_vld;
    logic signed [W-1:0]  r2_a, r2_b;
    logic signed [PW-1:0] r2_bb, r2_ac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_coef.valid;
            r2_vld <= r1_vld;
        end
        if (w_en) begin
            r1_a  <= i_coef.coef_a;
            r1_b  <= i_coef.coef_b;
            r1_c  <= i_coef.coef_c;
            r2_a  <= r1_a;
            r2_b  <= r1_b;
            r2_bb <= r1_b * r1_b;
            r2_ac <= r1_a * r1_c;
        end
    end

    // Stage 3: discriminant, classification and the square root radicand.
    logic signed [DW-1:0]   n3_d;
    logic signed [NBW-1:0]  n3_nb;
    logic signed [DENW-1:0] n3_den;
    qrs_pkg::t_kind         n3_kind;
    logic [2*RW-1:0]        n3_rad;
    logic                   r3_vld;
    logic [2*RW-1:0]        r3_rad;
    logic [SB1-1:0]         r3_sb;

    always_comb begin
        n3_d   = DW'(r2_bb) - (DW'(r2_ac) <<< 2);
        n3_nb  = -(NBW'(r2_b) <<< qrs_pkg::FRAC_SHIFT);
        n3_den = DENW'(r2_a) <<< 1;
        if (r2_a == '0) begin
            n3_kind = qrs_pkg::KIND_NOT_QUAD;
        end else if (n3_d[DW-1]) begin
            n3_kind = qrs_pkg::KIND_NO_ROOTS;
        end else if (n3_d == '0) begin
            n3_kind = qrs_pkg::KIND_DOUBLE;
        end else begin
            n3_kind = qrs_pkg::KIND_TWO;
        end
        // The radicand is D * 2^32; a negative D never reaches the root.
        if (n3_d[DW-1]) begin
            n3_rad = '0;
        end else begin
            n3_rad = {1'b0, n3_d[2*W:0], {qrs_pkg::SQRT_SHIFT{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= r2_vld;
        end
        if (w_en) begin
            r3_rad <= n3_rad;
            r3_sb  <= {n3_kind, n3_nb, n3_den};
        end
    end

    logic            w_sq_vld;
    logic [RW-1:0]   w_sq_root;
    logic [SB1-1:0]  w_sq_sb;

    qrs_sqrt #(
        .RW  (RW),
        .SBW (SB1)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r3_vld),
        .i_rad   (r3_rad),
        .i_sb    (r3_sb),
        .o_valid (w_sq_vld),
        .o_root  (w_sq_root),
        .o_sb    (w_sq_sb)
    );

    // Stage 4: numerators -b*2^16 +/- S, split into sign and magnitude.
    logic [1:0]             n4_kind;
    logic signed [NBW-1:0]  n4_nb;
    logic signed [DENW-1:0] n4_den;
    logic signed [NW-1:0]   n4_np, n4_nm;
    logic                   r4_vld;
    logic [QW-1:0]          r4_mp, r4_mm;
    logic [DENW-1:0]        r4_mden;
    logic                   r4_sp, r4_sm;
    logic [1:0]             r4_kind;

    always_comb begin
        {n4_kind, n4_nb, n4_den} = w_sq_sb;
        n4_np = NW'(n4_nb) + $signed(NW'(w_sq_root));
        n4_nm = NW'(n4_nb) - $signed(NW'(w_sq_root));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_en) begin
            r4_vld <= w_sq_vld;
        end
        if (w_en) begin
            r4_mp   <= QW'(n4_np[NW-1] ? -n4_np : n4_np);
            r4_mm   <= QW'(n4_nm[NW-1] ? -n4_nm : n4_nm);
            r4_mden <= n4_den[DENW-1] ? DENW'(-n4_den) : DENW'(n4_den);
            r4_sp   <= n4_np[NW-1] ^ n4_den[DENW-1];
            r4_sm   <= n4_nm[NW-1] ^ n4_den[DENW-1];
            r4_kind <= n4_kind;
        end
    end

    logic          w_dp_vld, w_dm_vld;
    logic [QW-1:0] w_qp, w_qm;
    logic [2:0]    w_dp_sb;
    logic          w_dm_sb;

    qrs_div #(
        .QW  (QW),
        .DW  (DENW),
        .SBW (3)
    ) u_div_plus (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r4_vld),
        .i_num   (r4_mp),
        .i_den   (r4_mden),
        .i_sb    ({r4_kind, r4_sp}),
        .o_valid (w_dp_vld),
        .o_quot  (w_qp),
        .o_sb    (w_dp_sb)
    );

    qrs_div #(
        .QW  (QW),
        .DW  (DENW),
        .SBW (1)
    ) u_div_minus (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r4_vld),
        .i_num   (r4_mm),
        .i_den   (r4_mden),
        .i_sb    (r4_sm),
        .o_valid (w_dm_vld),
        .o_quot  (w_qm),
        .o_sb    (w_dm_sb)
    );

    // Output stage: restore the signs, clamp to 32 bits and blank the
    // roots when the equation has none.
    logic signed [CW-1:0] n5_qp, n5_qm;
    logic                 n5_satp, n5_satm, n5_has;
    logic [1:0]           r_kind;
    logic signed [qrs_pkg::ROOT_WIDTH-1:0] r_rp, r_rm;
    logic                 r_sat;

    always_comb begin
        n5_qp   = w_dp_sb[0] ? -$signed(CW'(w_qp)) : $signed(CW'(w_qp));
        n5_qm   = w_dm_sb    ? -$signed(CW'(w_qm)) : $signed(CW'(w_qm));
        n5_satp = (n5_qp > MAX_ROOT) || (n5_qp < MIN_ROOT);
        n5_satm = (n5_qm > MAX_ROOT) || (n5_qm < MIN_ROOT);
        n5_has  = (w_dp_sb[2:1] == qrs_pkg::KIND_DOUBLE)
               || (w_dp_sb[2:1] == qrs_pkg::KIND_TWO);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_dp_vld && w_dm_vld;
        end
        if (w_en) begin
            r_kind <= w_dp_sb[2:1];
            if (!n5_has) begin
                r_rp  <= '0;
                r_rm  <= '0;
                r_sat <= 1'b0;
            end else begin
                r_rp  <= (n5_qp > MAX_ROOT) ? MAX_ROOT[31:0] :
                         (n5_qp < MIN_ROOT) ? MIN_ROOT[31:0] : n5_qp[31:0];
                r_rm  <= (n5_qm > MAX_ROOT) ? MAX_ROOT[31:0] :
                         (n5_qm < MIN_ROOT) ? MIN_ROOT[31:0] : n5_qm[31:0];
                r_sat <= n5_satp || n5_satm;
            end
        end
    end

    assign o_root.valid      = r_out_valid;
    assign o_root.kind       = r_kind;
    assign o_root.root_plus  = r_rp;
    assign o_root.root_minus = r_rm;
    assign o_root.saturated  = r_sat;

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench of the quadratic root solver
// Drives coefficient transfers, predicts every result in fixed point and
// compares each result transfer field by field, under random back pressure.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int  CW          = qrs_pkg::COEF_WIDTH_DEF;
    localparam int  LATENCY     = 2 * CW + 40;
    localparam int  RANDOM_EQNS = 930;
    localparam int  CYCLE_LIMIT = 400000;
    localparam logic signed [31:0] ROOT_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] ROOT_MIN = 32'sh80000000;

    localparam qrs_pkg::t_kind NOT_QUAD = qrs_pkg::KIND_NOT_QUAD;
    localparam qrs_pkg::t_kind NO_ROOTS = qrs_pkg::KIND_NO_ROOTS;
    localparam qrs_pkg::t_kind DOUBLE   = qrs_pkg::KIND_DOUBLE;
    localparam qrs_pkg::t_kind TWO      = qrs_pkg::KIND_TWO;

    typedef struct {
        qrs_pkg::t_kind           kind;
        logic signed [31:0]       rp;
        logic signed [31:0]       rm;
        logic                     sat;
    } t_solution;

    // One row of the directed table; has_exp marks rows whose answer is typed in.
    typedef struct {
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic signed [CW-1:0] c;
        bit                   has_exp;
        t_solution            sol;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    qrs_coef_if #(.COEF_WIDTH(CW)) coef_ch ();
    qrs_root_if                    root_ch ();

    quadratic_root_solver_unit #(.COEF_WIDTH(CW)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coef  (coef_ch.sink),
        .o_root  (root_ch.source)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    t_solution pending_q[$];
    int        mismatches;
    int        checked;
    int        cycles;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        kind_seen[4];
    int        sat_seen;

    // Integer square root of a value below 2^104, bit by bit from the top.
    function automatic logic [63:0] sqrt_floor(input logic [127:0] val);
        logic [63:0]  r;
        logic [63:0]  t;
        logic [127:0] sq;
        r = '0;
        for (int k = 52; k >= 0; k--) begin
            t  = r | (64'd1 << k);
            sq = 128'(t) * 128'(t);
            if (sq <= val) begin
                r = t;
            end
        end
        return r;
    endfunction

    // Clamps a 64-bit quotient to Q16.16 and notes any clamping.
    function automatic logic signed [31:0] clamp_root(input logic signed [63:0] q,
                                                      inout logic sat);
        if (q > 64'(ROOT_MAX)) begin
            sat = 1'b1;
            return ROOT_MAX;
        end
        if (q < 64'(ROOT_MIN)) begin
            sat = 1'b1;
            return ROOT_MIN;
        end
        return q[31:0];
    endfunction

    // Solves one equation. The discriminant is kept exact in 128 bits.
    function automatic t_solution solve_quadratic(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b,
                                                  input logic signed [CW-1:0] c);
        t_solution          s;
        logic signed [127:0] disc;
        logic [63:0]        root_d;
        logic signed [63:0] numer;
        logic signed [63:0] denom;
        s.kind = NOT_QUAD;
        s.rp   = '0;
        s.rm   = '0;
        s.sat  = 1'b0;
        if (a == 0) begin
            return s;
        end
        disc = 128'(b) * 128'(b) - 128'sd4 * 128'(a) * 128'(c);
        if (disc < 0) begin
            s.kind = NO_ROOTS;
            return s;
        end
        s.kind = (disc == 0) ? DOUBLE : TWO;
        root_d = sqrt_floor(128'(disc) << qrs_pkg::SQRT_SHIFT);
        numer  = -(64'(b)) * 64'sd65536;
        denom  = 64'sd2 * 64'(a);
        // SystemVerilog signed division truncates toward zero, as required.
        s.rp = clamp_root((numer + $signed(root_d)) / denom, s.sat);
        s.rm = clamp_root((numer - $signed(root_d)) / denom, s.sat);
        return s;
    endfunction

    // Result side: random stall, compare every transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_solution e;
        cycles <= cycles + 1;
        if (i_rst_n && root_ch.valid && root_ch.ready) begin
            if (pending_q.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) begin
                    $display("unexpected result transfer: kind %0d", root_ch.kind);
                end
            end else begin
                e = pending_q.pop_front();
                checked <= checked + 1;
                kind_seen[e.kind] <= kind_seen[e.kind] + 1;
                if (e.sat) begin
                    sat_seen <= sat_seen + 1;
                end
                if (root_ch.kind !== e.kind || root_ch.root_plus !== e.rp ||
                    root_ch.root_minus !== e.rm || root_ch.saturated !== e.sat) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) begin
                        $display("mismatch: exp kind %0d +%0d -%0d sat %0b, got %0d +%0d -%0d sat %0b",
                                 e.kind, e.rp, e.rm, e.sat, root_ch.kind,
                                 root_ch.root_plus, root_ch.root_minus, root_ch.saturated);
                    end
                end
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // The receiver's ready changes on the falling edge only.
    always @(negedge i_clk) begin
        root_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Presents one equation at a falling edge and waits for its transfer.
    // Valid stays high on return so that the next equation can follow at once.
    task automatic send_equation(input logic signed [CW-1:0] a,
                                 input logic signed [CW-1:0] b,
                                 input logic signed [CW-1:0] c,
                                 input bit has_exp,
                                 input t_solution typed);
        t_solution p;
        while ($urandom_range(99) < send_idle_pct) begin
            coef_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        coef_ch.valid  <= 1'b1;
        coef_ch.coef_a <= a;
        coef_ch.coef_b <= b;
        coef_ch.coef_c <= c;
        @(posedge i_clk);
        while (!coef_ch.ready) begin
            @(posedge i_clk);
        end
        p = solve_quadratic(a, b, c);
        if (has_exp && (p.kind != typed.kind || p.rp != typed.rp ||
                        p.rm != typed.rm || p.sat != typed.sat)) begin
            $display("predictor disagrees with table row a=%0d b=%0d c=%0d", a, b, c);
            mismatches++;
        end
        pending_q.push_back(has_exp ? typed : p);
        @(negedge i_clk);
    endtask

    // Random coefficient, biased toward the extremes and small values.
    function automatic logic signed [CW-1:0] pick_coef();
        case ($urandom_range(7))
            0: return {1'b0, {(CW-1){1'b1}}};
            1: return {1'b1, {(CW-1){1'b0}}};
            2: return '0;
            3: return CW'($signed($urandom_range(16)) - 8);
            4: return CW'($signed($urandom_range(1024)) - 512);
            default: return CW'($urandom);
        endcase
    endfunction

    // Directed rows. Typed answers come straight from the definition:
    // a = 0, negative discriminant, and simple exact roots.
    t_row directed[] = '{
        '{16'sd0,      16'sd256,    16'sd256,    1, '{NOT_QUAD, 0, 0, 0}},
        '{16'sd0,      -16'sd32768, 16'sd32767,  1, '{NOT_QUAD, 0, 0, 0}},
        '{16'sd256,    16'sd0,      16'sd256,    1, '{NO_ROOTS, 0, 0, 0}},
        '{-16'sd32768, 16'sd0,      -16'sd32768, 1, '{NO_ROOTS, 0, 0, 0}},
        '{16'sd32767,  16'sd0,      16'sd32767,  1, '{NO_ROOTS, 0, 0, 0}},
        // x^2 - 1 = 0: roots +1 and -1 in Q16.16.
        '{16'sd256,    16'sd0,      -16'sd256,   1, '{TWO, 32'sd65536, -32'sd65536, 0}},
        // x^2 - 2x + 1 = 0: double root at 1.
        '{16'sd256,    -16'sd512,   16'sd256,    1, '{DOUBLE, 32'sd65536, 32'sd65536, 0}},
        // b = c = 0: double root at zero.
        '{16'sd256,    16'sd0,      16'sd0,      1, '{DOUBLE, 0, 0, 0}},
        // Smallest a with large b: one root at zero, the other just inside
        // the lower limit, so nothing clamps.
        '{16'sd1,      16'sd32767,  16'sd0,      1, '{TWO, 0, -32'sd2147418112, 0}},
        '{-16'sd1,     16'sd32767,  16'sd0,      0, '{NOT_QUAD, 0, 0, 0}},
        '{16'sd1,      -16'sd32768, 16'sd32767,  0, '{NOT_QUAD, 0, 0, 0}},
        '{-16'sd32768, -16'sd32768, 16'sd32767,  0, '{NOT_QUAD, 0, 0, 0}},
        '{16'sd32767,  16'sd32767,  -16'sd32768, 0, '{NOT_QUAD, 0, 0, 0}},
        '{-16'sd32768, 16'sd32767,  16'sd32767,  0, '{NOT_QUAD, 0, 0, 0}},
        '{16'sd1,      16'sd1,      -16'sd1,     0, '{NOT_QUAD, 0, 0, 0}},
        '{16'sd1,      16'sd2,      16'sd1,      0, '{NOT_QUAD, 0, 0, 0}},
        '{-16'sd1,     16'sd2,      -16'sd1,     0, '{NOT_QUAD, 0, 0, 0}},
        '{16'sd3,      16'sd7,      16'sd2,      0, '{NOT_QUAD, 0, 0, 0}},
        '{-16'sd21846, 16'sd12345,  16'sd5555,   0, '{NOT_QUAD, 0, 0, 0}}
    };

    initial begin
        logic signed [CW-1:0] ra;
        logic signed [CW-1:0] rb;
        logic signed [CW-1:0] rc;
        logic signed [CW-1:0] root_i;
        logic signed [CW-1:0] root_j;
        int          wait_cycles;
        t_solution   none;

        none          = '{NOT_QUAD, 0, 0, 0};
        mismatches    = 0;
        checked       = 0;
        cycles        = 0;
        sat_seen      = 0;
        kind_seen     = '{0, 0, 0, 0};
        send_idle_pct = 38;
        recv_idle_pct = 85;
        i_rst_n        = 1'b0;
        coef_ch.valid  = 1'b0;
        coef_ch.coef_a = '0;
        coef_ch.coef_b = '0;
        coef_ch.coef_c = '0;
        root_ch.ready  = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[i]) begin
            send_equation(directed[i].a, directed[i].b, directed[i].c,
                          directed[i].has_exp, directed[i].sol);
        end

        // Random part in three idling phases. Half of the equations are built
        // from chosen roots so that real roots, double roots and exact
        // discriminants turn up often; the rest are raw random coefficients.
        for (int n = 0; n < RANDOM_EQNS; n++) begin
            if (n == RANDOM_EQNS / 3) begin
                send_idle_pct = 85;
                recv_idle_pct = 38;
            end else if (n == 2 * RANDOM_EQNS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // Once, the sender holds off until the pipeline has drained.
            if (n == RANDOM_EQNS / 2) begin
                coef_ch.valid <= 1'b0;
                while (pending_q.size() != 0) begin
                    @(negedge i_clk);
                end
            end
            if ($urandom_range(1) == 0) begin
                // a*(x - i)*(x - j) with small integer roots, a in Q8.8.
                ra     = CW'($signed($urandom_range(64)) - 32);
                root_i = CW'($signed($urandom_range(8)) - 4);
                root_j = ($urandom_range(3) == 0) ? root_i
                                                  : CW'($signed($urandom_range(8)) - 4);
                rb     = -ra * (root_i + root_j);
                rc     = ra * root_i * root_j;
            end else begin
                ra = pick_coef();
                rb = pick_coef();
                rc = pick_coef();
            end
            send_equation(ra, rb, rc, 0, none);
        end
        coef_ch.valid <= 1'b0;

        wait_cycles = 0;
        while (pending_q.size() != 0 && wait_cycles < 100 * LATENCY + 20000) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (LATENCY + 10) @(negedge i_clk);

        $display("checked %0d equations: %0d not quadratic, %0d without real roots,",
                 checked, kind_seen[0], kind_seen[1]);
        $display("%0d double roots, %0d two roots, %0d with a clamped root",
                 kind_seen[2], kind_seen[3], sat_seen);
        if (mismatches == 0 && pending_q.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
